[hdl/reflectance_color_classifier_core_defines.svh]
// Assertion macros used by the reflectance colour classifier core.
`ifndef REFLECTANCE_COLOR_CLASSIFIER_CORE_DEFINES_SVH
`define REFLECTANCE_COLOR_CLASSIFIER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Check that the property holds on every clock edge outside reset.
`define RCC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rcc assertion failed");
// Check that the condition never occurs on a clock edge outside reset.
`define RCC_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("rcc forbidden condition seen");
`else
`define RCC_ASSERT(label, prop)
`define RCC_ASSERT_NEVER(label, cond)
`endif

`endif

[hdl/rcc_pkg.sv]
// Types and constants of the reflectance colour classifier.
package rcc_pkg;

  localparam int unsigned AdcBits    = 10;
  localparam int unsigned NumColors  = 5;
  localparam int unsigned ColorW     = 3;
  localparam int unsigned ClassW     = 3;
  // Samples per calibration run; a power of two, so the average is a shift.
  localparam int unsigned CalSamples = 16;
  localparam int unsigned CntW       = (CalSamples > 1) ? $clog2(CalSamples) : 1;
  localparam int unsigned CalShift   = $clog2(CalSamples);
  localparam int unsigned SumW       = AdcBits + CalShift;

  typedef enum logic {
    CmdClassify  = 1'b0,
    CmdCalibrate = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [ColorW-1:0]   color;
    logic [AdcBits-1:0]  ambient;
    logic [AdcBits-1:0]  lit;
  } in_word_t;

  typedef struct packed {
    logic [AdcBits-1:0]  reflectance;
    logic [ClassW-1:0]   nearest_class;
    logic [AdcBits-1:0]  distance;
    logic                cal_stored;
    logic                cal_rejected;
  } out_word_t;

  typedef logic [NumColors-1:0][AdcBits-1:0] level_tbl_t;

  typedef struct packed {
    logic                en;
    logic [ColorW-1:0]   color;
    logic [AdcBits-1:0]  refl;
  } cal_req_t;

  typedef struct packed {
    logic stored;
    logic rejected;
  } cal_rsp_t;

endpackage

[hdl/reflectance_color_classifier_core.sv]
// Top level of the reflectance colour classifier: input register, logic, result register.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_word_i) takes one sample pair per
//   word: a command (classify or calibrate), a colour index and the ambient and
//   lit converter samples. Output channel (out_valid_o / out_ready_i /
//   out_word_o) returns one result word per input word, in order.
//   An accepted word passes the input register, then the result register,
//   where out_valid_o rises. Throughput: one word per cycle while the
//   receiver does not stall; the path between the two registers is the
//   reflectance subtract, five parallel distance compares and the
//   calibration accumulate.
//   A calibrate word updates the run state as it moves into the result
//   register, so the next word already sees the new level table.
//   Reset clears the level table, the calibration run and both valid flags.
//   When the receiver stalls, the result register holds its word and the
//   input register fills; in_ready_o drops only once both are occupied.
`include "reflectance_color_classifier_core_defines.svh"

module reflectance_color_classifier_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rcc_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rcc_pkg::out_word_t out_word_o
);
  import rcc_pkg::*;

  logic                in_vld_q;
  in_word_t            in_q;
  logic                out_vld_q;
  out_word_t           out_q, out_d;

  logic                advance;
  logic [AdcBits-1:0]  refl;
  level_tbl_t          levels;
  logic [ClassW-1:0]   match_class;
  logic [AdcBits-1:0]  match_dist;
  cal_req_t            cal_req;
  cal_rsp_t            cal_rsp;

  // Advance the held word whenever the result register is free or draining
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  // Floor the reflectance at zero
  assign refl = (in_q.lit > in_q.ambient) ? '0 : (in_q.ambient - in_q.lit);

  rcc_level_match u_match (
    .levels_i (levels),
    .refl_i   (refl),
    .class_o  (match_class),
    .dist_o   (match_dist)
  );

  assign cal_req.en    = advance && (in_q.cmd == CmdCalibrate);
  assign cal_req.color = in_q.color;
  assign cal_req.refl  = refl;

  rcc_cal_unit u_cal (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (cal_req),
    .rsp_o    (cal_rsp),
    .levels_o (levels)
  );

  // Assemble the result word
  always_comb begin
    out_d               = '0;
    out_d.reflectance   = refl;
    out_d.cal_stored    = cal_rsp.stored;
    out_d.cal_rejected  = cal_rsp.rejected;
    if (in_q.cmd == CmdClassify) begin
      out_d.nearest_class = match_class;
      out_d.distance      = match_dist;
    end
  end

  // Track occupancy of both registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Capture payloads
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_word_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  // A word never both completes a run and is rejected
  `RCC_ASSERT_NEVER(a_flags_exclusive,
                    out_valid_o && out_word_o.cal_stored && out_word_o.cal_rejected)
  // Calibrate results carry no class or distance
  `RCC_ASSERT(a_cal_no_class,
              (out_valid_o && (out_word_o.cal_stored || out_word_o.cal_rejected)) |->
              (out_word_o.nearest_class == '0 && out_word_o.distance == '0))
  // The class index always names one of the stored levels
  `RCC_ASSERT(a_class_range,
              out_valid_o |-> (out_word_o.nearest_class < ClassW'(NumColors)))
  // A held input word moves on as soon as the result register frees up
  `RCC_ASSERT(a_no_bubble,
              (in_vld_q && !out_vld_q) |=> out_vld_q)

endmodule

[hdl/rcc_level_match.sv]
// Nearest calibration level search over the five stored levels.
module rcc_level_match (
  input  rcc_pkg::level_tbl_t          levels_i,
  input  logic [rcc_pkg::AdcBits-1:0]  refl_i,
  output logic [rcc_pkg::ClassW-1:0]   class_o,
  output logic [rcc_pkg::AdcBits-1:0]  dist_o
);
  import rcc_pkg::*;

  logic [NumColors-1:0][AdcBits-1:0] lvl_dist;

  // Form the absolute difference to each level in parallel
  always_comb begin
    for (int i = 0; i < NumColors; i++) begin
      lvl_dist[i] = (levels_i[i] > refl_i) ? (levels_i[i] - refl_i) : (refl_i - levels_i[i]);
    end
  end

  // Keep the first strictly smaller distance, so the lowest index wins a tie
  always_comb begin
    class_o = '0;
    dist_o  = lvl_dist[0];
    for (int i = 1; i < NumColors; i++) begin
      if (lvl_dist[i] < dist_o) begin
        class_o = ClassW'(i);
        dist_o  = lvl_dist[i];
      end
    end
  end

endmodule

[hdl/rcc_cal_unit.sv]
// Calibration run accumulator and level table of the colour classifier.
module rcc_cal_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rcc_pkg::cal_req_t  req_i,
  output rcc_pkg::cal_rsp_t  rsp_o,
  output rcc_pkg::level_tbl_t levels_o
);
  import rcc_pkg::*;

  level_tbl_t          level_q, level_d;
  logic [SumW-1:0]     run_sum_q, run_sum_d;
  logic [CntW-1:0]     run_cnt_q, run_cnt_d;
  logic [ColorW-1:0]   run_color_q, run_color_d;

  logic                color_ok;
  logic                same_run;
  logic [SumW-1:0]     base_sum;
  logic [CntW-1:0]     base_cnt;
  logic [SumW-1:0]     sum_new;
  logic                run_done;

  assign color_ok = (req_i.color < ColorW'(NumColors));
  assign same_run = (req_i.color == run_color_q);
  assign base_sum = same_run ? run_sum_q : '0;
  assign base_cnt = same_run ? run_cnt_q : '0;
  assign sum_new  = base_sum + SumW'(req_i.refl);
  assign run_done = (base_cnt == CntW'(CalSamples - 1));

  // Reject an out-of-range colour, else accumulate the word, restart on a colour change, store the average when full
  always_comb begin
    level_d      = level_q;
    run_sum_d    = run_sum_q;
    run_cnt_d    = run_cnt_q;
    run_color_d  = run_color_q;
    rsp_o        = '0;
    if (req_i.en) begin
      if (!color_ok) begin
        rsp_o.rejected = 1'b1;
      end else begin
        run_color_d = req_i.color;
        if (run_done) begin
          for (int i = 0; i < NumColors; i++) begin
            if (req_i.color == ColorW'(i)) begin
              level_d[i] = sum_new[SumW-1 -: AdcBits];
            end
          end
          run_sum_d    = '0;
          run_cnt_d    = '0;
          rsp_o.stored = 1'b1;
        end else begin
          run_sum_d = sum_new;
          run_cnt_d = base_cnt + CntW'(1);
        end
      end
    end
  end

  // Hold calibration state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= '0;
      run_sum_q   <= '0;
      run_cnt_q   <= '0;
      run_color_q <= '0;
    end else begin
      level_q     <= level_d;
      run_sum_q   <= run_sum_d;
      run_cnt_q   <= run_cnt_d;
      run_color_q <= run_color_d;
    end
  end

  assign levels_o = level_q;

endmodule
